### sv/ntnbe_pkg.sv
// ----------------------------------------------------------------------------
// ntnbe_pkg
// Shared types, codes and constants of the n-tuple board evaluator.
// ----------------------------------------------------------------------------
package ntnbe_pkg;

  localparam int WINDOW_STATES = 81;
  localparam int WINDOW_SIDE  = 6;
  localparam int WINDOW_COUNT = WINDOW_SIDE * WINDOW_SIDE;
  localparam int FEATURE_ROWS = WINDOW_COUNT * WINDOW_STATES;
  localparam logic [9:0] WINDOW_MASK = 10'h303;
  localparam int CELL_WEIGHT [4] = '{1, 3, 9, 27};
  localparam int SCORE_MARGIN = 300;

  localparam logic [1:0] MODE_LOAD_FEAT = 2'd0;
  localparam logic [1:0] MODE_LOAD_BIAS = 2'd1;
  localparam logic [1:0] MODE_LOAD_OUTW = 2'd2;
  localparam logic [1:0] MODE_EVAL      = 2'd3;

  localparam logic [2:0] CFG_CLIP_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_OUTPUT_QUANT = 3'd1;
  localparam logic [2:0] CFG_EVAL_SCALE   = 3'd2;
  localparam logic [2:0] CFG_SCORE_OFFSET = 3'd3;
  localparam logic [2:0] CFG_SCORE_LIMIT  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_ACC, ST_OUT, ST_DRAIN, ST_DIV, ST_BIAS, ST_SCALE, ST_DONE
  } state_t;

  // Base-3 code of the 2x2 window whose top-left cell sits at bit shift.
  // A cell holding both stones counts as own.
  function automatic logic [6:0] window_code(input logic [63:0] own,
                                             input logic [63:0] other,
                                             input logic [5:0]  shift);
    logic [63:0] os;
    logic [63:0] ts;
    logic [9:0]  om;
    logic [9:0]  tm;
    logic [3:0]  o;
    logic [3:0]  t;
    logic [6:0]  code;
    os = own >> shift;
    ts = other >> shift;
    om = os[9:0] & WINDOW_MASK;
    tm = ts[9:0] & WINDOW_MASK & ~om;
    o = {om[9], om[8], om[1], om[0]};
    t = {tm[9], tm[8], tm[1], tm[0]};
    code = '0;
    for (int c = 0; c < 4; c++) begin
      code = code + 7'(CELL_WEIGHT[c] * int'(o[c]) + 2 * CELL_WEIGHT[c] * int'(t[c]));
    end
    return code;
  endfunction

endpackage

### sv/ntnbe_ram.sv
// ----------------------------------------------------------------------------
// ntnbe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ntnbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ntuple_nnue_board_eval_top.sv
// ----------------------------------------------------------------------------
// ntuple_nnue_board_eval_top
// N-tuple NNUE board evaluator with squared clipped ReLU output layer.
//
// Load requests (feature weight, hidden bias, output weight) are written to
// their memories in the cycle they are accepted. For an evaluate request,
// one lane per cycle is read from a one-read, one-write accumulator memory,
// first to load the biases, then once for each of the 36 2x2 windows to add
// the selected feature row, then once more for the clamp, square and
// output-weight product; the lane pipeline then drains. Two 64-step
// bit-serial divides (by clip_limit, then by clip_limit*output_quant), with
// a bias step (adding score_offset) and a scale step (by eval_scale) between
// them, finish the score. The score sits in an output register, so the next
// request is taken while the score waits. Memories are not cleared: evaluate
// only after every feature row, bias and output weight it reads has been
// loaded. Write configuration only while idle.
// ----------------------------------------------------------------------------
module ntuple_nnue_board_eval_top import ntnbe_pkg::*; #(
  parameter int LANE_COUNT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [11:0]        row_index,
  input  logic [6:0]         lane_index,
  input  logic signed [15:0] weight_value,
  input  logic [63:0]        own_stones,
  input  logic [63:0]        other_stones,
  input  logic               pov_flip,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] score
);

  localparam int LW         = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int FW_DEPTH   = FEATURE_ROWS * LANE_COUNT;
  localparam int FAW        = $clog2(FW_DEPTH);
  localparam int ROW_STRIDE = WINDOW_STATES * LANE_COUNT;
  localparam logic [LW-1:0] LAST_LANE = LW'(LANE_COUNT - 1);
  localparam logic [2:0]    LAST_WIN  = 3'(WINDOW_SIDE - 1);

  // configuration registers
  logic [9:0]         clip_limit;
  logic [9:0]         output_quant;
  logic [11:0]        eval_scale;
  logic signed [31:0] score_offset;
  logic [14:0]        score_limit;

  state_t state, state_next;

  logic        in_fire, is_eval, lane_ok, row_ok;
  logic        issue;
  logic [63:0] own_r, other_r;
  logic        flip_r;
  logic [9:0]  qa;
  logic [19:0] qab;
  logic [9:0]  qa_c, qb_c;

  logic [LW-1:0]  lane;
  logic [2:0]     ri, rj;
  logic [FAW-1:0] win_base;
  logic [6:0]     code;

  // memory ports
  logic           fw_we, bias_we, ow_we, acc_we;
  logic [FAW-1:0] fw_waddr, fw_raddr;
  logic [15:0]    fw_rdata, bias_rdata, ow_rdata;
  logic [LW-1:0]  acc_waddr;
  logic [31:0]    acc_wdata, acc_rdata, acc_val;

  // lane pipeline
  logic              p1_v, p2_v, p3_v;
  state_t            p1_kind;
  logic [LW-1:0]     p1_lane;
  logic              fwd_hit;
  logic [31:0]       fwd_data;
  logic [9:0]        clamped;
  logic [19:0]       p2_sq;
  logic signed [15:0] p2_w;
  logic signed [36:0] p3_prod;
  logic signed [63:0] sum;

  // bit-serial divider
  logic [63:0]        div_dvd;
  logic [19:0]        div_rem, div_dsr;
  logic               div_neg, div_second;
  logic [5:0]         div_cnt;
  logic [20:0]        rem_sh, rem_n;
  logic               div_ge;
  logic signed [63:0] q_signed;
  logic signed [47:0] biased;
  logic signed [63:0] scaled;
  logic signed [63:0] lim, clamped_ev, final_ev;
  logic               out_free;

  assign in_fire  = in_valid && in_ready;
  assign is_eval  = (mode == MODE_EVAL);
  assign lane_ok  = (32'(lane_index) < 32'(LANE_COUNT));
  assign row_ok   = (32'(row_index) < 32'(FEATURE_ROWS));
  assign qa_c     = (clip_limit == '0) ? 10'd1 : clip_limit;
  assign qb_c     = (output_quant == '0) ? 10'd1 : output_quant;
  assign out_free = !out_valid || out_ready;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit   <= 10'd255;
      output_quant <= 10'd64;
      eval_scale   <= 12'd400;
      score_offset <= '0;
      score_limit  <= 15'(32'd30000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_LIMIT:   clip_limit   <= cfg_data[9:0];
        CFG_OUTPUT_QUANT: output_quant <= cfg_data[9:0];
        CFG_EVAL_SCALE:   eval_scale   <= cfg_data[11:0];
        CFG_SCORE_OFFSET: score_offset <= cfg_data;
        CFG_SCORE_LIMIT:  score_limit  <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // ---- loads: write straight into the weight memories ----
  assign fw_we    = in_fire && (mode == MODE_LOAD_FEAT) && lane_ok && row_ok;
  assign bias_we  = in_fire && (mode == MODE_LOAD_BIAS) && lane_ok;
  assign ow_we    = in_fire && (mode == MODE_LOAD_OUTW) && lane_ok;
  assign fw_waddr = FAW'(32'(row_index) * LANE_COUNT) + FAW'(lane_index);

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && is_eval) state_next = ST_INIT;
      ST_INIT:  if (lane == LAST_LANE) state_next = ST_ACC;
      ST_ACC:   if (lane == LAST_LANE && ri == LAST_WIN && rj == LAST_WIN) begin
                  state_next = ST_OUT;
                end
      ST_OUT:   if (lane == LAST_LANE) state_next = ST_DRAIN;
      ST_DRAIN: if (!(p1_v || p2_v || p3_v)) state_next = ST_DIV;
      ST_DIV:   if (div_cnt == 6'd63) state_next = div_second ? ST_DONE : ST_BIAS;
      ST_BIAS:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---- state outputs ----
  always_comb begin
    in_ready = (state == ST_IDLE);
    issue    = (state == ST_INIT) || (state == ST_ACC) || (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- lane and window counters ----
  always_ff @(posedge clk) begin
    if (rst) begin
      lane     <= '0;
      ri       <= '0;
      rj       <= '0;
      win_base <= '0;
    end else if (in_fire && is_eval) begin
      lane     <= '0;
      ri       <= '0;
      rj       <= '0;
      win_base <= '0;
    end else if (issue) begin
      lane <= (lane == LAST_LANE) ? '0 : lane + 1'b1;
      if (state == ST_ACC && lane == LAST_LANE) begin
        win_base <= win_base + FAW'(ROW_STRIDE);
        if (rj == LAST_WIN) begin
          rj <= '0;
          ri <= ri + 1'b1;
        end else begin
          rj <= rj + 1'b1;
        end
      end
    end
  end

  // latch the board and divisors at the start of an evaluation
  always_ff @(posedge clk) begin
    if (in_fire && is_eval) begin
      own_r   <= own_stones;
      other_r <= other_stones;
      flip_r  <= pov_flip;
      qa      <= qa_c;
      qab     <= qa_c * qb_c;
    end
  end

  // window (ri, rj) starts at bit ri*8+rj
  assign code     = window_code(own_r, other_r, {ri, rj});
  assign fw_raddr = win_base + FAW'(32'(code) * LANE_COUNT) + FAW'(lane);

  ntnbe_ram #(.WIDTH(16), .DEPTH(FW_DEPTH), .AW(FAW)) u_fw_mem (
    .clk(clk), .we(fw_we), .waddr(fw_waddr), .wdata(weight_value),
    .raddr(fw_raddr), .rdata(fw_rdata)
  );

  ntnbe_ram #(.WIDTH(16), .DEPTH(LANE_COUNT), .AW(LW)) u_bias_mem (
    .clk(clk), .we(bias_we), .waddr(LW'(lane_index)), .wdata(weight_value),
    .raddr(lane), .rdata(bias_rdata)
  );

  ntnbe_ram #(.WIDTH(16), .DEPTH(LANE_COUNT), .AW(LW)) u_ow_mem (
    .clk(clk), .we(ow_we), .waddr(LW'(lane_index)), .wdata(weight_value),
    .raddr(lane), .rdata(ow_rdata)
  );

  ntnbe_ram #(.WIDTH(32), .DEPTH(LANE_COUNT), .AW(LW)) u_acc_mem (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(lane), .rdata(acc_rdata)
  );

  // ---- read-modify-write on the accumulators ----
  // Forward a write that lands on the lane being read in the same cycle
  // (only a single-lane configuration gets there).
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v && (p1_kind == ST_OUT);
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_kind  <= state;
    p1_lane  <= lane;
    fwd_hit  <= acc_we && (acc_waddr == lane);
    fwd_data <= acc_wdata;
  end

  assign acc_val   = fwd_hit ? fwd_data : acc_rdata;
  assign acc_we    = p1_v && ((p1_kind == ST_INIT) || (p1_kind == ST_ACC));
  assign acc_waddr = p1_lane;
  assign acc_wdata = (p1_kind == ST_INIT) ? {{16{bias_rdata[15]}}, bias_rdata}
                                          : acc_val + {{16{fw_rdata[15]}}, fw_rdata};

  // clamp to [0, clip], square, weight, accumulate
  always_comb begin
    if (acc_val[31]) begin
      clamped = '0;
    end else if (acc_val > {22'd0, qa}) begin
      clamped = qa;
    end else begin
      clamped = acc_val[9:0];
    end
  end

  always_ff @(posedge clk) begin
    p2_sq   <= clamped * clamped;
    p2_w    <= signed'(ow_rdata);
    p3_prod <= signed'({1'b0, p2_sq}) * p2_w;
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_eval) begin
      sum <= '0;
    end else if (p3_v) begin
      sum <= sum + {{27{p3_prod[36]}}, p3_prod};
    end
  end

  // ---- bit-serial magnitude divider, one quotient bit per cycle ----
  assign rem_sh   = {div_rem, div_dvd[63]};
  assign div_ge   = (rem_sh >= {1'b0, div_dsr});
  assign rem_n    = div_ge ? (rem_sh - {1'b0, div_dsr}) : rem_sh;
  assign q_signed = div_neg ? -signed'(div_dvd) : signed'(div_dvd);
  assign scaled   = 64'(biased * signed'({1'b0, eval_scale}));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt    <= '0;
      div_second <= 1'b0;
    end else begin
      priority if (state == ST_DRAIN && state_next == ST_DIV) begin
        div_dvd    <= sum[63] ? 64'(-sum) : 64'(sum);
        div_neg    <= sum[63];
        div_dsr    <= {10'd0, qa};
        div_rem    <= '0;
        div_cnt    <= '0;
        div_second <= 1'b0;
      end else if (state == ST_DIV) begin
        div_dvd <= {div_dvd[62:0], div_ge};
        div_rem <= rem_n[19:0];
        div_cnt <= div_cnt + 1'b1;
      end else if (state == ST_BIAS) begin
        biased <= q_signed[47:0] + 48'(score_offset);
      end else if (state == ST_SCALE) begin
        div_dvd    <= scaled[63] ? 64'(-scaled) : 64'(scaled);
        div_neg    <= scaled[63];
        div_dsr    <= qab;
        div_rem    <= '0;
        div_cnt    <= '0;
        div_second <= 1'b1;
      end else begin
      end
    end
  end

  // ---- final clamp, view flip and output register ----
  assign lim = signed'({49'd0, score_limit});

  always_comb begin
    if (q_signed > lim) begin
      clamped_ev = lim;
    end else if (q_signed < -lim) begin
      clamped_ev = -lim;
    end else begin
      clamped_ev = q_signed;
    end
    final_ev = flip_r ? -clamped_ev : clamped_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      score <= final_ev[15:0];
    end
  end

  // ---- assertions ----
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(p1_v || p2_v || p3_v))
    else $error("lane pipeline busy while idle");

  a_acc_write_phase: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> (state == ST_INIT || state == ST_ACC || state == ST_OUT))
    else $error("accumulator write outside its pass");

  a_div_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !(p1_v || p2_v || p3_v))
    else $error("divide started before the output sum settled");

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && $past(state) == ST_DIV) |-> div_second)
    else $error("score taken after the first divide");

endmodule
